>>> design/urxrb_pkg.sv
// Shared types and constants of the UART receive ring buffer.
`default_nettype none
package urxrb_pkg;

  localparam int RING_DEPTH_DEF = 4096;
  localparam int MAX_BURST_DEF  = 64;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 7;
  localparam int AVAIL_W  = 12;
  localparam int CNT_W    = 32;
  localparam int AVAIL_MAX = 4095;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic              is_read;
    logic              overrun;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic [LEN_W-1:0]  want;
  } cmd_t;

endpackage
`default_nettype wire

>>> design/urxrb_front.sv
// Front end: accepts commands and turns them into queued work entries.
`default_nettype none
module urxrb_front import urxrb_pkg::*; #(
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  wire logic              start_i,
  input  wire logic              action_i,
  input  wire logic              overrun_flag_i,
  input  wire logic              data_ready_i,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  input  wire logic [LEN_W-1:0]  pop_limit_i,
  input  wire logic              q_full_i,
  output logic                   busy_o,
  output logic                   push_o,
  output cmd_t                   cmd_o
);

  localparam logic [LEN_W-1:0] BurstMax = LEN_W'(MAX_BURST);

  always_comb begin
    busy_o = q_full_i;
    push_o = start_i && !q_full_i;
    cmd_o.is_read = action_i;
    cmd_o.overrun = overrun_flag_i && !action_i;
    cmd_o.ready   = data_ready_i && !action_i;
    cmd_o.rx_byte = rx_byte_i;
    if (pop_limit_i > BurstMax) begin
      cmd_o.want = BurstMax;
    end else begin
      cmd_o.want = pop_limit_i;
    end
  end

endmodule
`default_nettype wire

>>> design/urxrb_queue.sv
// Short command queue between the front end and the execution back end.
`default_nettype none
module urxrb_queue import urxrb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  cmd_t            entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  always_comb begin
    full_o  = (count_q == CntW'(QUEUE_DEPTH));
    valid_o = (count_q != '0);
    cmd_o   = entry_q[rd_ptr_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

>>> design/urxrb_back.sv
// Back end: ring memory, pointers, counters and result sequencing.
`default_nettype none
module urxrb_back import urxrb_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire cmd_t               cmd_i,
  output logic                    q_pop_o,
  output logic                    valid_o,
  output logic [BYTE_W-1:0]       data_byte_o,
  output logic                    byte_valid_o,
  output logic                    last_o,
  output logic [AVAIL_W-1:0]      available_o,
  output logic [CNT_W-1:0]        received_total_o,
  output logic [CNT_W-1:0]        overflow_total_o
);

  localparam int LvlW = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
  localparam logic [LvlW-1:0] PtrLast = LvlW'(RING_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [LvlW-1:0]    wp_q, wp_d;
  logic [LvlW-1:0]    rp_q, rp_d;
  logic [LvlW-1:0]    level_q, level_d;
  logic [LEN_W-1:0]   remain_q, remain_d;
  logic [CNT_W-1:0]   recv_q, recv_d;
  logic [CNT_W-1:0]   ovf_q, ovf_d;
  logic               out_valid_q, out_valid_d;
  logic               byte_valid_q, byte_valid_d;
  logic               last_q, last_d;
  logic [AVAIL_W-1:0] avail_q, avail_d;
  logic [LEN_W-1:0]   cnt;
  logic               mem_we, mem_re;

  logic [BYTE_W-1:0]  mem_q [RING_DEPTH];
  logic [BYTE_W-1:0]  rdata_q;

  function automatic logic [AVAIL_W-1:0] sat_level(logic [LvlW-1:0] lvl);
    logic [31:0] lvl32;
    lvl32 = 32'(lvl);
    if (lvl32 > 32'(AVAIL_MAX)) begin
      return AVAIL_W'(AVAIL_MAX);
    end
    return AVAIL_W'(lvl32);
  endfunction

  always_comb begin
    state_d      = state_q;
    wp_d         = wp_q;
    rp_d         = rp_q;
    level_d      = level_q;
    remain_d     = remain_q;
    recv_d       = recv_q;
    ovf_d        = ovf_q;
    avail_d      = avail_q;
    out_valid_d  = 1'b0;
    byte_valid_d = 1'b0;
    last_d       = 1'b0;
    q_pop_o      = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    if (32'(cmd_i.want) < 32'(level_q)) begin
      cnt = cmd_i.want;
    end else begin
      cnt = LEN_W'(level_q);
    end
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (!cmd_i.is_read) begin
            ovf_d = ovf_q + CNT_W'(cmd_i.overrun);
            if (cmd_i.ready) begin
              recv_d = recv_q + 1'b1;
              if (level_q == PtrLast) begin
                ovf_d = ovf_q + CNT_W'(cmd_i.overrun) + 1'b1;
              end else begin
                mem_we  = 1'b1;
                wp_d    = (wp_q == PtrLast) ? '0 : wp_q + 1'b1;
                level_d = level_q + 1'b1;
              end
            end
            out_valid_d = 1'b1;
            last_d      = 1'b1;
            avail_d     = sat_level(level_d);
          end else if (cnt == '0) begin
            out_valid_d = 1'b1;
            last_d      = 1'b1;
            avail_d     = sat_level(level_q);
          end else begin
            level_d  = level_q - LvlW'(cnt);
            avail_d  = sat_level(level_d);
            remain_d = cnt;
            state_d  = ST_POP;
          end
        end
      end
      ST_POP: begin
        mem_re       = 1'b1;
        rp_d         = (rp_q == PtrLast) ? '0 : rp_q + 1'b1;
        remain_d     = remain_q - 1'b1;
        out_valid_d  = 1'b1;
        byte_valid_d = 1'b1;
        last_d       = (remain_q == LEN_W'(1));
        if (remain_q == LEN_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wp_q         <= '0;
      rp_q         <= '0;
      level_q      <= '0;
      remain_q     <= '0;
      recv_q       <= '0;
      ovf_q        <= '0;
      avail_q      <= '0;
      out_valid_q  <= 1'b0;
      byte_valid_q <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      wp_q         <= wp_d;
      rp_q         <= rp_d;
      level_q      <= level_d;
      remain_q     <= remain_d;
      recv_q       <= recv_d;
      ovf_q        <= ovf_d;
      avail_q      <= avail_d;
      out_valid_q  <= out_valid_d;
      byte_valid_q <= byte_valid_d;
      last_q       <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= cmd_i.rx_byte;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rp_q];
    end
  end

  always_comb begin
    valid_o          = out_valid_q;
    byte_valid_o     = byte_valid_q;
    data_byte_o      = byte_valid_q ? rdata_q : '0;
    last_o           = last_q;
    available_o      = avail_q;
    received_total_o = recv_q;
    overflow_total_o = ovf_q;
  end

endmodule
`default_nettype wire

>>> design/uart_rx_ring_buffer.sv
// Top level of the UART receive ring buffer with overflow counting.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+---------------------------------------
//   command  | start, busy               | action, overrun_flag, data_ready,
//            |                           | rx_byte, pop_limit
//   result   | valid_o                   | data_byte, byte_valid, last, available,
//            |                           | received_total, overflow_total
//
// A command is taken when start is high and busy is low, and enters a two-entry queue.
// The back end takes one queued command per cycle when free. A receive event or an empty
// read puts its single result on the ports in the cycle after the back end takes it.
// A read that pops n bytes moves the back end to ST_POP, which puts out one byte per cycle,
// each read from the ring memory into a register; no new command is taken until ST_POP
// ends. busy rises only when the queue is full. Reset clears pointers, counters and the
// queue; the ring memory is not cleared. Results cannot be held off by the receiver.
`default_nettype none
module uart_rx_ring_buffer import urxrb_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int MAX_BURST  = MAX_BURST_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               action_i,
  input  wire logic               overrun_flag_i,
  input  wire logic               data_ready_i,
  input  wire logic [BYTE_W-1:0]  rx_byte_i,
  input  wire logic [LEN_W-1:0]   pop_limit_i,
  output logic                    valid_o,
  output logic [BYTE_W-1:0]       data_byte_o,
  output logic                    byte_valid_o,
  output logic                    last_o,
  output logic [AVAIL_W-1:0]      available_o,
  output logic [CNT_W-1:0]        received_total_o,
  output logic [CNT_W-1:0]        overflow_total_o
);

  logic q_full, q_push, q_valid, q_pop;
  cmd_t cmd_in, cmd_out;

  urxrb_front #(
    .MAX_BURST(MAX_BURST)
  ) u_front (
    .start_i        (start),
    .action_i       (action_i),
    .overrun_flag_i (overrun_flag_i),
    .data_ready_i   (data_ready_i),
    .rx_byte_i      (rx_byte_i),
    .pop_limit_i    (pop_limit_i),
    .q_full_i       (q_full),
    .busy_o         (busy),
    .push_o         (q_push),
    .cmd_o          (cmd_in)
  );

  urxrb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (cmd_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (cmd_out)
  );

  urxrb_back #(
    .RING_DEPTH(RING_DEPTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .cmd_i            (cmd_out),
    .q_pop_o          (q_pop),
    .valid_o          (valid_o),
    .data_byte_o      (data_byte_o),
    .byte_valid_o     (byte_valid_o),
    .last_o           (last_o),
    .available_o      (available_o),
    .received_total_o (received_total_o),
    .overflow_total_o (overflow_total_o)
  );

endmodule
`default_nettype wire
